### design/uetp_pkg.sv
`timescale 1ns / 1ps
package uetp_pkg;

  // endpoint count and derived index widths
  localparam int EP_COUNT = 4;
  localparam int EP_W     = (EP_COUNT > 1) ? $clog2(EP_COUNT) : 1;
  localparam int SLOT_W   = EP_W + 1;

  // endpoints backed by configuration registers
  localparam int CFG_EP   = 4;
  localparam int CFG_W    = 10;
  localparam int NUM_REGS = 2 * CFG_EP;
  localparam int REG_IW   = $clog2(NUM_REGS);
  localparam int ADDR_W   = REG_IW + 2;

  localparam logic [CFG_W-1:0] TX_LEN_EP0_RST  = 10'd64;
  localparam logic [CFG_W-1:0] RX_SIZE_EP0_RST = 10'd64;

  localparam logic [3:0] PID_SETUP = 4'd13;
  localparam logic [3:0] PID_IN    = 4'd9;

  typedef enum logic [1:0] {
    OP_WRITE     = 2'd0,
    OP_SET_ADDR  = 2'd1,
    OP_TOKEN     = 2'd2,
    OP_BUS_RESET = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_BUSY    = 2'd2
  } status_t;

  // configuration view handed to the core
  typedef struct packed {
    logic [CFG_EP-1:0][CFG_W-1:0] tx_len;
    logic [CFG_EP-1:0][CFG_W-1:0] rx_size;
  } cfg_t;

  // input request, first field in the highest bits
  typedef struct packed {
    logic        token_odd;
    logic        token_is_tx;
    logic [3:0]  token_pid;
    logic [6:0]  new_device_address;
    logic [15:0] transfer_length;
    logic [31:0] buffer_address;
    logic [3:0]  endpoint;
  } item_t;

  // result, first field in the highest bits
  typedef struct packed {
    logic [6:0]       address_value;
    logic             address_load;
    logic [CFG_W-1:0] rx_count;
    logic             rx_rearm;
    logic             tx_data1;
    logic [CFG_W-1:0] tx_count;
    logic [31:0]      tx_address;
    logic             tx_slot_odd;
    logic [3:0]       tx_endpoint;
    logic             tx_issue;
    status_t          status;
  } res_t;

  localparam int ITEM_W = $bits(item_t);
  localparam int RES_W  = $bits(res_t);
  localparam int IN_DW  = ((ITEM_W + 7) / 8) * 8;
  localparam int OUT_DW = ((RES_W + 7) / 8) * 8;

  // max packet size, zero for endpoints without a register
  function automatic logic [CFG_W-1:0] max_packet(input cfg_t c, input logic [3:0] ep);
    logic [CFG_W-1:0] v;
    v = '0;
    for (int i = 0; i < CFG_EP; i++) begin
      if (ep == 4'(i)) v = c.tx_len[i];
    end
    return v;
  endfunction

  // receive re-arm size, zero for endpoints without a register
  function automatic logic [CFG_W-1:0] rx_size(input cfg_t c, input logic [3:0] ep);
    logic [CFG_W-1:0] v;
    v = '0;
    for (int i = 0; i < CFG_EP; i++) begin
      if (ep == 4'(i)) v = c.rx_size[i];
    end
    return v;
  endfunction

endpackage

### design/uetp_cfg_regs.sv
`timescale 1ns / 1ps
module uetp_cfg_regs
  import uetp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [CFG_W-1:0]  regs_r [NUM_REGS];
  logic [REG_IW-1:0] idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite && pready;

  // register file, tx lengths first then rx sizes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        if (i == 0) begin
          regs_r[i] <= TX_LEN_EP0_RST;
        end else if (i == CFG_EP) begin
          regs_r[i] <= RX_SIZE_EP0_RST;
        end else begin
          regs_r[i] <= '0;
        end
      end
    end else if (wr_en) begin
      regs_r[idx] <= pwdata[CFG_W-1:0];
    end
  end

  // read back
  assign prdata = {{(32-CFG_W){1'b0}}, regs_r[idx]};

  always_comb begin
    for (int i = 0; i < CFG_EP; i++) begin
      cfg.tx_len[i]  = regs_r[i];
      cfg.rx_size[i] = regs_r[CFG_EP + i];
    end
  end

endmodule

### design/usb_endpoint_tx_packetizer_core.sv
`timescale 1ns / 1ps
// channel   ports                  payload
// input     in_tvalid/in_tready    in_tdata request fields, in_tuser opcode
// output    out_tvalid/out_tready  out_tdata result fields
// config    cfg_psel..cfg_prdata   eight 10-bit registers at 4*i
//
// every request is handled in order: its endpoint entry is read from the
// pending-transfer memory when it is accepted, then updated and the result register loaded
// the single port of that memory and the read-modify-write set this order
// reset is synchronous and active low; no clearing pass, the memory has no reset
// a result held by out_tready stalls the update cycle; a new request is taken
// only once the previous one has been written back
module usb_endpoint_tx_packetizer_core
  import uetp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // endpoint, buffer_address, transfer_length, new_device_address,
  // token_pid, token_is_tx, token_odd
  input  logic [IN_DW-1:0]  in_tdata,
  // opcode
  input  logic [1:0]        in_tuser,
  input  logic              in_tvalid,
  output logic              in_tready,
  // status, tx_issue, tx_endpoint, tx_slot_odd, tx_address, tx_count,
  // tx_data1, rx_rearm, rx_count, address_load, address_value
  output logic [OUT_DW-1:0] out_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;

  cfg_t   cfg;
  state_t state_r, state_nxt;
  item_t  item_r, in_item;
  op_t    op_r;
  res_t   res_r, res_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;

  // pending transfer memory: {address, length}
  logic [47:0]        mem [EP_COUNT];
  logic [47:0]        rd_data_r;
  logic [47:0]        mem_wdata;
  logic               mem_we;

  // per-endpoint and per-slot control flops, deferred device address
  logic [EP_COUNT-1:0]   valid_r, valid_nxt;
  logic [EP_COUNT-1:0]   odd_r, odd_nxt;
  logic [EP_COUNT-1:0]   tog_r, tog_nxt;
  logic [2*EP_COUNT-1:0] owned_r, owned_nxt;
  logic [6:0]            deferred_r, deferred_nxt;

  logic             in_fire, exec_fire;
  logic             ep_ok, try_issue, base_valid, issued;
  logic [EP_W-1:0]  epi;
  logic [SLOT_W-1:0] slot;
  logic [31:0]      base_addr;
  logic [15:0]      base_len, rem_len;
  logic [CFG_W-1:0] mp, pkt_len;

  uetp_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  assign in_item    = item_t'(in_tdata[ITEM_W-1:0]);
  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign exec_fire  = (state_r == ST_EXEC) && (!out_tvalid_r || out_tready);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_DW-RES_W){1'b0}}, res_r};

  // request capture, payload only
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_item;
      op_r   <= op_t'(in_tuser);
    end
  end

  // memory: read on request, write back on update
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_data_r <= mem[in_item.endpoint[EP_W-1:0]];
    end
    if (exec_fire && mem_we) begin
      mem[epi] <= mem_wdata;
    end
  end

  // packet cut from the loaded request or the stored transfer
  assign epi       = item_r.endpoint[EP_W-1:0];
  assign ep_ok     = ({1'b0, item_r.endpoint} < 5'(EP_COUNT));
  assign base_addr = (op_r == OP_WRITE) ? item_r.buffer_address : rd_data_r[47:16];
  assign base_len  = (op_r == OP_WRITE) ? item_r.transfer_length : rd_data_r[15:0];
  assign mp        = max_packet(cfg, item_r.endpoint);
  assign pkt_len   = (base_len < {6'b0, mp}) ? base_len[CFG_W-1:0] : mp;
  assign rem_len   = base_len - {6'b0, pkt_len};
  assign slot      = {epi, odd_r[epi]};

  // request decode and endpoint update
  always_comb begin
    res_nxt      = '0;
    valid_nxt    = valid_r;
    odd_nxt      = odd_r;
    tog_nxt      = tog_r;
    owned_nxt    = owned_r;
    deferred_nxt = deferred_r;
    mem_we       = 1'b0;
    try_issue    = 1'b0;
    base_valid   = 1'b0;
    issued       = 1'b0;
    case (op_r)
      OP_WRITE: begin
        if (!ep_ok) begin
          res_nxt.status = STAT_INVALID;
        end else if (valid_r[epi]) begin
          res_nxt.status = STAT_BUSY;
        end else begin
          base_valid     = 1'b1;
          try_issue      = 1'b1;
          mem_we         = 1'b1;
          valid_nxt[epi] = 1'b1;
        end
      end
      OP_SET_ADDR: begin
        deferred_nxt = item_r.new_device_address;
      end
      OP_TOKEN: begin
        if (!ep_ok) begin
          res_nxt.status = STAT_INVALID;
        end else begin
          // completed transmit frees its slot before any flush
          if (item_r.token_is_tx) begin
            owned_nxt[{epi, item_r.token_odd}] = 1'b0;
          end
          if (item_r.token_pid == PID_SETUP) begin
            tog_nxt[epi] = 1'b1;
          end else if (item_r.token_pid == PID_IN) begin
            if (deferred_r != 7'd0) begin
              res_nxt.address_load  = 1'b1;
              res_nxt.address_value = deferred_r;
              deferred_nxt          = 7'd0;
            end
            try_issue  = 1'b1;
            base_valid = valid_r[epi];
          end
          if (!item_r.token_is_tx) begin
            res_nxt.rx_rearm = 1'b1;
            res_nxt.rx_count = rx_size(cfg, item_r.endpoint);
          end
        end
      end
      default: begin
        // bus reset: endpoint 0 back to idle, address cleared
        valid_nxt[0]         = 1'b0;
        odd_nxt[0]           = 1'b0;
        tog_nxt[0]           = 1'b0;
        owned_nxt[0]         = 1'b0;
        owned_nxt[1]         = 1'b0;
        res_nxt.address_load = 1'b1;
      end
    endcase

    // hand a packet to the current slot if it is free
    if (try_issue && base_valid && !owned_nxt[slot]) begin
      issued              = 1'b1;
      res_nxt.tx_issue    = 1'b1;
      res_nxt.tx_endpoint = item_r.endpoint;
      res_nxt.tx_slot_odd = odd_r[epi];
      res_nxt.tx_address  = base_addr;
      res_nxt.tx_count    = pkt_len;
      res_nxt.tx_data1    = tog_r[epi];
      owned_nxt[slot]     = 1'b1;
      odd_nxt[epi]        = ~odd_r[epi];
      tog_nxt[epi]        = ~tog_r[epi];
      valid_nxt[epi]      = (rem_len != 16'd0);
      mem_we              = 1'b1;
    end
    mem_wdata = issued ? {base_addr + {22'b0, pkt_len}, rem_len} : {base_addr, base_len};
  end

  // sequencer next state and result register
  always_comb begin
    state_nxt      = state_r;
    out_tvalid_nxt = out_tvalid_r;
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (exec_fire) begin
          state_nxt      = ST_IDLE;
          out_tvalid_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    if (exec_fire) begin
      res_r <= res_nxt;
    end
  end

  // endpoint control flops
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      odd_r      <= '0;
      tog_r      <= '0;
      owned_r    <= '0;
      deferred_r <= '0;
    end else if (exec_fire) begin
      valid_r    <= valid_nxt;
      odd_r      <= odd_nxt;
      tog_r      <= tog_nxt;
      owned_r    <= owned_nxt;
      deferred_r <= deferred_nxt;
    end
  end

  // checks
  ast_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_EXEC))
    else $error("accepted request did not enter update cycle");

  ast_issue_owns: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_fire && issued) |=> owned_r[$past(slot)])
    else $error("issued slot not marked owned");

  ast_bus_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_fire && op_r == OP_BUS_RESET) |=> (!valid_r[0] && !owned_r[0] && !owned_r[1]))
    else $error("bus reset left endpoint 0 active");

  ast_result_after_update: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire |=> out_tvalid_r)
    else $error("update cycle produced no result");

endmodule

### sim/uetp_packet_checker.sv
`timescale 1ns / 1ps
module uetp_packet_checker
  import uetp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [IN_DW-1:0]  in_tdata,
  input  logic [1:0]        in_tuser,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [OUT_DW-1:0] out_tdata,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  input  logic              cfg_pready,
  output int unsigned       errors,
  output int unsigned       awaiting
);

  // shadow of the endpoint state
  logic [31:0]      xfer_addr  [EP_COUNT];
  logic [15:0]      xfer_len   [EP_COUNT];
  logic             xfer_live  [EP_COUNT];
  logic             ep_odd     [EP_COUNT];
  logic             ep_toggle  [EP_COUNT];
  logic             slot_busy  [2*EP_COUNT];
  logic [6:0]       held_dev_addr;

  // shadow of the registers
  logic [CFG_W-1:0] tx_max        [CFG_EP];
  logic [CFG_W-1:0] rx_rearm_size [CFG_EP];

  res_t             packet_q[$];
  item_t            seen_rq;
  res_t             due;
  res_t             got;
  int               reg_idx;

  // cut the next packet of an endpoint into its current slot, if free
  task automatic cut_packet(input int ep, inout res_t r);
    int               slot;
    logic [CFG_W-1:0] mp;
    logic [15:0]      n;
    if (!xfer_live[ep]) return;
    slot = 2 * ep + int'(ep_odd[ep]);
    if (slot_busy[slot]) return;
    mp = (ep < CFG_EP) ? tx_max[ep] : '0;
    n = (xfer_len[ep] < 16'(mp)) ? xfer_len[ep] : 16'(mp);
    r.tx_issue    = 1'b1;
    r.tx_endpoint = 4'(ep);
    r.tx_slot_odd = ep_odd[ep];
    r.tx_address  = xfer_addr[ep];
    r.tx_count    = n[CFG_W-1:0];
    r.tx_data1    = ep_toggle[ep];
    slot_busy[slot] = 1'b1;
    ep_odd[ep]      = ~ep_odd[ep];
    ep_toggle[ep]   = ~ep_toggle[ep];
    xfer_len[ep]    = xfer_len[ep] - n;
    if (xfer_len[ep] == 16'd0) xfer_live[ep] = 1'b0;
    else xfer_addr[ep] = xfer_addr[ep] + 32'(n);
  endtask

  // expected result of one request, updating the shadow state
  task automatic predict_request(input op_t op, input item_t rq, output res_t r);
    int ep;
    r = '0;
    ep = int'(rq.endpoint);
    case (op)
      OP_WRITE: begin
        if (ep >= EP_COUNT) begin
          r.status = STAT_INVALID;
        end else if (xfer_live[ep]) begin
          r.status = STAT_BUSY;
        end else begin
          xfer_addr[ep] = rq.buffer_address;
          xfer_len[ep]  = rq.transfer_length;
          xfer_live[ep] = 1'b1;
          cut_packet(ep, r);
        end
      end
      OP_SET_ADDR: begin
        held_dev_addr = rq.new_device_address;
      end
      OP_TOKEN: begin
        if (ep >= EP_COUNT) begin
          r.status = STAT_INVALID;
        end else begin
          // transmit completion frees its slot before any flush
          if (rq.token_is_tx) slot_busy[2 * ep + int'(rq.token_odd)] = 1'b0;
          if (rq.token_pid == PID_SETUP) begin
            ep_toggle[ep] = 1'b1;
          end else if (rq.token_pid == PID_IN) begin
            if (held_dev_addr != 7'd0) begin
              r.address_load  = 1'b1;
              r.address_value = held_dev_addr;
              held_dev_addr   = 7'd0;
            end
            cut_packet(ep, r);
          end
          if (!rq.token_is_tx) begin
            r.rx_rearm = 1'b1;
            r.rx_count = (ep < CFG_EP) ? rx_rearm_size[ep] : '0;
          end
        end
      end
      default: begin
        // bus reset only touches endpoint 0 and the address register
        xfer_live[0] = 1'b0;
        xfer_len[0]  = '0;
        xfer_addr[0] = '0;
        ep_odd[0]    = 1'b0;
        ep_toggle[0] = 1'b0;
        slot_busy[0] = 1'b0;
        slot_busy[1] = 1'b0;
        r.address_load  = 1'b1;
        r.address_value = 7'd0;
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] seen);
    if (seen !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, seen);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < EP_COUNT; i++) begin
        xfer_live[i] = 1'b0;
        ep_odd[i]    = 1'b0;
        ep_toggle[i] = 1'b0;
      end
      for (int i = 0; i < 2 * EP_COUNT; i++) slot_busy[i] = 1'b0;
      for (int i = 0; i < CFG_EP; i++) begin
        tx_max[i]        = '0;
        rx_rearm_size[i] = '0;
      end
      tx_max[0]        = TX_LEN_EP0_RST;
      rx_rearm_size[0] = RX_SIZE_EP0_RST;
      held_dev_addr    = 7'd0;
      packet_q.delete();
      errors = 0;
    end else begin
      // register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        reg_idx = int'(cfg_paddr >> 2);
        if (reg_idx < CFG_EP) tx_max[reg_idx] = cfg_pwdata[CFG_W-1:0];
        else if (reg_idx < NUM_REGS) rx_rearm_size[reg_idx - CFG_EP] = cfg_pwdata[CFG_W-1:0];
      end
      // accepted request
      if (in_tvalid && in_tready) begin
        seen_rq = item_t'(in_tdata[ITEM_W-1:0]);
        predict_request(op_t'(in_tuser), seen_rq, due);
        packet_q.push_back(due);
      end
      // accepted result
      if (out_tvalid && out_tready) begin
        got = res_t'(out_tdata[RES_W-1:0]);
        if (packet_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          errors++;
        end else begin
          due = packet_q.pop_front();
          check_field("status", 32'(due.status), 32'(got.status));
          check_field("tx_issue", 32'(due.tx_issue), 32'(got.tx_issue));
          check_field("tx_endpoint", 32'(due.tx_endpoint), 32'(got.tx_endpoint));
          check_field("tx_slot_odd", 32'(due.tx_slot_odd), 32'(got.tx_slot_odd));
          check_field("tx_address", due.tx_address, got.tx_address);
          check_field("tx_count", 32'(due.tx_count), 32'(got.tx_count));
          check_field("tx_data1", 32'(due.tx_data1), 32'(got.tx_data1));
          check_field("rx_rearm", 32'(due.rx_rearm), 32'(got.rx_rearm));
          check_field("rx_count", 32'(due.rx_count), 32'(got.rx_count));
          check_field("address_load", 32'(due.address_load), 32'(got.address_load));
          check_field("address_value", 32'(due.address_value), 32'(got.address_value));
        end
      end
    end
    awaiting = packet_q.size();
  end

endmodule

### sim/usb_endpoint_tx_packetizer_core_tb.sv
`timescale 1ns / 1ps
module usb_endpoint_tx_packetizer_core_tb;
  import uetp_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n;
  logic [IN_DW-1:0]  in_tdata;
  logic [1:0]        in_tuser;
  logic              in_tvalid;
  logic              in_tready;
  logic [OUT_DW-1:0] out_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [31:0]       cfg_pwdata;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  int unsigned       mismatches;
  int unsigned       awaiting;
  bit                quiet;
  bit                hold_off_req;

  always #4 clk = ~clk;

  usb_endpoint_tx_packetizer_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  uetp_packet_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .errors      (mismatches),
    .awaiting    (awaiting)
  );

  // overall time limit
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (60) @(negedge clk);
        hold_off_req = 1'b0;
        out_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // register write: setup then access, the caller closes the transfer
  task automatic write_reg(input int idx, input logic [CFG_W-1:0] v);
    logic [31:0] word;
    word = $urandom;
    word[CFG_W-1:0] = v;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_W'(idx * 4);
    cfg_pwdata  <= word;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
  endtask

  task automatic load_config(input int phase);
    logic [CFG_W-1:0] tx_v [CFG_EP];
    logic [CFG_W-1:0] rx_v [CFG_EP];
    for (int i = 0; i < CFG_EP; i++) begin
      case (phase)
        0: begin
          tx_v[i] = (i == 0) ? 10'd16 : (i == 1) ? 10'd1023 : (i == 2) ? 10'd1 : 10'd0;
          rx_v[i] = (i == 0) ? 10'd1023 : (i == 1) ? 10'd0 : (i == 2) ? 10'd7 : 10'd64;
        end
        1: begin
          tx_v[i] = 10'd1023;
          rx_v[i] = 10'd1023;
        end
        2: begin
          tx_v[i] = 10'd0;
          rx_v[i] = 10'd0;
        end
        default: begin
          tx_v[i] = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 1023))
                                                  : 10'($urandom_range(1, 64));
          rx_v[i] = 10'($urandom_range(0, 1023));
        end
      endcase
    end
    for (int i = 0; i < CFG_EP; i++) write_reg(i, tx_v[i]);
    for (int i = 0; i < CFG_EP; i++) write_reg(CFG_EP + i, rx_v[i]);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // offer one request and hold it until taken
  task automatic send_request(input op_t op, input logic [3:0] ep, input logic [31:0] addr,
                              input logic [15:0] len, input logic [6:0] dev,
                              input logic [3:0] pid, input logic tx, input logic odd);
    item_t rq;
    rq.endpoint           = ep;
    rq.buffer_address     = addr;
    rq.transfer_length    = len;
    rq.new_device_address = dev;
    rq.token_pid          = pid;
    rq.token_is_tx        = tx;
    rq.token_odd          = odd;
    in_tdata  <= IN_DW'(rq);
    in_tuser  <= op;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic pause_input(input int n);
    in_tvalid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // stop offering and wait until every result is back
  task automatic settle();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (awaiting != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // mostly transfers and IN/completion tokens on real endpoints
  task automatic random_request();
    int          pick;
    op_t         op;
    logic [3:0]  ep;
    logic [15:0] len;
    logic [3:0]  pid;
    pick = $urandom_range(0, 99);
    op = (pick < 30) ? OP_WRITE : (pick < 36) ? OP_SET_ADDR :
         (pick < 39) ? OP_BUS_RESET : OP_TOKEN;
    ep = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(4, 15)) : 4'($urandom_range(0, 3));
    pick = $urandom_range(0, 99);
    len = (pick < 5) ? 16'($urandom_range(0, 65535)) : (pick < 13) ? 16'd0
                                                     : 16'($urandom_range(1, 200));
    pick = $urandom_range(0, 99);
    pid = (pick < 55) ? PID_IN : (pick < 70) ? PID_SETUP : 4'($urandom_range(0, 15));
    send_request(op, ep, $urandom, len, 7'($urandom_range(0, 127)), pid,
                 ($urandom_range(0, 4) != 0), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    rst_n        = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    in_tvalid    = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    quiet        = 1'b0;
    hold_off_req = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part
    load_config(0);
    send_request(OP_WRITE, 4'd0, 32'hFFFF_FFF0, 16'd40, 7'd0, 4'd0, 1'b0, 1'b0);
    send_request(OP_WRITE, 4'd0, 32'h0000_1000, 16'd5, 7'd0, 4'd0, 1'b0, 1'b0);
    send_request(OP_WRITE, 4'd15, 32'hFFFF_FFFF, 16'hFFFF, 7'd0, 4'd0, 1'b0, 1'b0);
    send_request(OP_TOKEN, 4'd4, 32'd0, 16'd0, 7'd0, PID_IN, 1'b1, 1'b1);
    send_request(OP_SET_ADDR, 4'd0, 32'd0, 16'd0, 7'd127, 4'd0, 1'b0, 1'b0);
    send_request(OP_TOKEN, 4'd0, 32'd0, 16'd0, 7'd0, PID_IN, 1'b1, 1'b0);
    send_request(OP_TOKEN, 4'd0, 32'd0, 16'd0, 7'd0, PID_IN, 1'b1, 1'b1);
    send_request(OP_TOKEN, 4'd0, 32'd0, 16'd0, 7'd0, PID_SETUP, 1'b0, 1'b0);
    send_request(OP_WRITE, 4'd0, 32'h1234_5678, 16'd0, 7'd0, 4'd0, 1'b0, 1'b0);
    send_request(OP_WRITE, 4'd3, 32'h0000_0100, 16'd100, 7'd0, 4'd0, 1'b0, 1'b0);
    send_request(OP_WRITE, 4'd3, 32'h0000_0200, 16'd1, 7'd0, 4'd0, 1'b0, 1'b0);
    send_request(OP_TOKEN, 4'd3, 32'd0, 16'd0, 7'd0, PID_IN, 1'b1, 1'b0);
    send_request(OP_WRITE, 4'd1, 32'd0, 16'hFFFF, 7'd0, 4'd0, 1'b0, 1'b0);
    send_request(OP_WRITE, 4'd2, 32'h8000_0000, 16'd1, 7'd0, 4'd0, 1'b0, 1'b0);
    send_request(OP_TOKEN, 4'd1, 32'd0, 16'd0, 7'd0, 4'd0, 1'b0, 1'b0);
    send_request(OP_TOKEN, 4'd1, 32'd0, 16'd0, 7'd0, 4'd15, 1'b1, 1'b0);
    send_request(OP_WRITE, 4'd2, 32'h8000_0010, 16'd1, 7'd0, 4'd0, 1'b0, 1'b0);
    // slot still owned: accepted without a packet
    send_request(OP_WRITE, 4'd2, 32'h8000_0020, 16'd3, 7'd0, 4'd0, 1'b0, 1'b0);
    send_request(OP_TOKEN, 4'd2, 32'd0, 16'd0, 7'd0, PID_IN, 1'b1, 1'b0);
    send_request(OP_SET_ADDR, 4'd0, 32'd0, 16'd0, 7'h2A, 4'd0, 1'b0, 1'b0);
    send_request(OP_BUS_RESET, 4'd0, 32'd0, 16'd0, 7'd0, 4'd0, 1'b0, 1'b0);
    send_request(OP_TOKEN, 4'd0, 32'd0, 16'd0, 7'd0, PID_IN, 1'b0, 1'b1);
    send_request(OP_SET_ADDR, 4'd0, 32'd0, 16'd0, 7'd0, 4'd0, 1'b0, 1'b0);
    send_request(OP_TOKEN, 4'd0, 32'd0, 16'd0, 7'd0, PID_IN, 1'b1, 1'b0);

    // random phases, each under its own register setting
    for (int phase = 1; phase <= 4; phase++) begin
      settle();
      load_config(phase);
      if (phase == 4) quiet = 1'b1;
      for (int n = 0; n < ((phase == 2) ? 40 : (phase == 1) ? 90 : 120); n++) begin
        if (phase == 1 && n == 10) hold_off_req = 1'b1;
        if (phase == 3 && n == 60) settle();
        if (!quiet && $urandom_range(0, 3) == 0) pause_input($urandom_range(1, 3));
        random_request();
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && awaiting == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
design/uetp_pkg.sv
design/uetp_cfg_regs.sv
design/usb_endpoint_tx_packetizer_core.sv
sim/uetp_packet_checker.sv
sim/usb_endpoint_tx_packetizer_core_tb.sv
